@@ rtl/bhp_pkg.sv @@
// ----------------------------------------------------------------------------
// bhp_pkg: shared types and constants of the bucket histogram
// Opcodes, sequencer states and fixed scale of the percentile arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
package bhp_pkg;

  localparam int unsigned OpW = 3;
  localparam int unsigned ValW = 64;
  localparam int unsigned PctW = 17;
  localparam int unsigned WideW = 192;
  localparam logic [PctW-1:0] PctScale = 17'd100000;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 3'd0,
    OP_PCT   = 3'd1,
    OP_CLEAR = 3'd2,
    OP_WRB   = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_UPD,
    ST_CLEAR,
    ST_PCT_STOP,
    ST_PCT_SUM,
    ST_PCT_TGT,
    ST_PCT_WALK,
    ST_PCT_NUM,
    ST_PCT_DIV,
    ST_READ,
    ST_DONE
  } state_e;

  // shift-add multiplier control
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mul_ctl_t;

endpackage
`default_nettype wire

@@ rtl/bucket_histogram_percentile.sv @@
// ----------------------------------------------------------------------------
// bucket_histogram_percentile: bucketed histogram with percentile query
// Sequencer over bucket bounds and counts that shares one multiplier and
// one divider for interpolation.
// ----------------------------------------------------------------------------
// Use: items enter on s_axis (tdata holds sample_value, bound_value,
// bucket_index, percent_milli from bit 0 up; tuser holds the opcode). Each
// item yields exactly one result on m_axis (tdata: percentile_value,
// bucket_count, hit_bucket, total_count, max_value from bit 0 up).
// The block takes one item at a time; s_axis_tready is low while it works
// or holds a result. Work per operation:
// Add sample: one bound compare per cycle.
// Clear: one counter cleared per cycle.
// Write bound, read bucket and unused opcodes: a pass through the read state.
// Percentile: one multiply for the target, one per walked bucket, three
// more multiplies and a division.
// A result stays in the output register until m_axis_tready is high; the
// next item can be taken in the cycle after it leaves.
// Reset zeroes counts, total and maximum; bounds must be written before
// the first sample.
// ----------------------------------------------------------------------------
`default_nettype none
module bucket_histogram_percentile
  import bhp_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // sample_value[63:0], bound_value[127:64], bucket_index[131:128],
  // percent_milli[148:132], zero fill
  input  wire logic [151:0] s_axis_tdata,
  // opcode[2:0]
  input  wire logic [2:0]   s_axis_tuser,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // percentile_value[63:0], bucket_count[95:64], hit_bucket[99:96],
  // total_count[131:100], max_value[195:132]
  output      logic [199:0] m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(NUM_BUCKETS);
  localparam logic [COUNT_BITS-1:0] CntMax = '1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_BUCKETS - 1);

  state_e state_q, state_d;

  logic [ValW-1:0]       bnd_q [NUM_BUCKETS];
  logic [COUNT_BITS-1:0] cnt_q [NUM_BUCKETS];
  logic [ValW-1:0]       max_q;
  logic [COUNT_BITS-1:0] tot_q;

  logic [OpW-1:0]  op_q;
  logic [ValW-1:0] smp_q, bval_q;
  logic [3:0]      bidx_q;
  logic [PctW-1:0] pct_q;
  logic [IdxW-1:0] i_q, stop_q;
  logic [ValW-1:0] nev_q, lcum_q, sum_q;
  logic [WideW-1:0] tgt_q;
  logic [1:0]      sub_q;
  logic [ValW-1:0] res_q;
  logic [199:0]    out_q, out_d;
  logic            ov_q;

  logic             mstart, dstart, ddone;
  logic [WideW-1:0] ma, pout;
  logic [ValW-1:0]  mb, quo;
  mul_ctl_t         mctl;

  bhp_mul u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .ctl_o(mctl), .p_o(pout)
  );
  bhp_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(tgt_q), .den_i(pout),
    .done_o(ddone), .quo_o(quo)
  );

  logic [ValW-1:0] cnt64, sat_sum, lp, rp, span, diff, r_sum;
  logic [ValW:0]   add_w;
  logic            accept;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    cnt64   = ValW'(cnt_q[i_q]);
    add_w   = {1'b0, sum_q} + {1'b0, cnt64};
    sat_sum = add_w[ValW] ? '1 : add_w[ValW-1:0];
    lp      = bnd_q[(i_q == '0) ? '0 : i_q - 1'b1];
    rp      = bnd_q[i_q];
    span    = (rp > lp) ? rp - lp : '0;
    diff    = sum_q - lcum_q;
    r_sum   = lp + quo;
  end

  // sequencer; sub_q steps through multiplies within a state
  always_comb begin
    state_d = state_q;
    mstart  = 1'b0;
    dstart  = 1'b0;
    ma      = '0;
    mb      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority case (s_axis_tuser)
            OP_ADD:   state_d = ST_ADD_SCAN;
            OP_PCT:   state_d = ST_PCT_STOP;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_READ;
          endcase
        end
      end
      ST_ADD_SCAN: if (smp_q <= bnd_q[i_q] || i_q == LastIdx) state_d = ST_ADD_UPD;
      ST_ADD_UPD:  state_d = ST_DONE;
      ST_CLEAR:    if (i_q == LastIdx) state_d = ST_DONE;
      ST_READ:     state_d = ST_DONE;
      ST_PCT_STOP: if (max_q <= bnd_q[i_q] || i_q == LastIdx - 1'b1) state_d = ST_PCT_SUM;
      ST_PCT_SUM: begin
        if (i_q == stop_q) begin
          state_d = ST_PCT_TGT;
          mstart  = 1'b1;
          ma      = WideW'(sat_sum);
          mb      = ValW'(pct_q);
        end
      end
      ST_PCT_TGT: if (mctl.done) state_d = (stop_q == '0) ? ST_DONE : ST_PCT_WALK;
      ST_PCT_WALK: begin
        if (sub_q == 2'd0) begin
          mstart = 1'b1;
          ma     = WideW'(sat_sum);
          mb     = ValW'(PctScale);
        end else if (mctl.done) begin
          if (pout >= tgt_q) begin
            state_d = (sat_sum != sum_q && span != '0) ? ST_PCT_NUM : ST_DONE;
          end else if (i_q == stop_q - 1'b1) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_PCT_NUM: begin
        // lcum*scale, then (tgt-that)*span, then diff*scale
        if (sub_q == 2'd0) begin
          mstart = 1'b1;
          ma     = WideW'(lcum_q);
          mb     = ValW'(PctScale);
        end else if (mctl.done && sub_q == 2'd1) begin
          mstart = 1'b1;
          ma     = tgt_q - pout;
          mb     = span;
        end else if (mctl.done && sub_q == 2'd2) begin
          mstart = 1'b1;
          ma     = WideW'(diff);
          mb     = ValW'(PctScale);
        end else if (mctl.done) begin
          dstart  = 1'b1;
          state_d = ST_PCT_DIV;
        end
      end
      ST_PCT_DIV: if (ddone) state_d = ST_DONE;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // result item assembled from the finished operation
  always_comb begin
    out_d = '0;
    out_d[195:132] = max_q;
    out_d[131:100] = (COUNT_BITS > 32 && |(ValW'(tot_q) >> 32)) ? 32'hFFFF_FFFF
                     : 32'(ValW'(tot_q));
    if (op_q == OP_PCT) out_d[63:0] = res_q;
    if (op_q == OP_ADD) out_d[99:96] = 4'(i_q);
    if (op_q == OP_READ && 32'(bidx_q) < NUM_BUCKETS)
      out_d[95:64] = (COUNT_BITS > 32 && |(ValW'(cnt_q[IdxW'(bidx_q)]) >> 32))
                     ? 32'hFFFF_FFFF : 32'(ValW'(cnt_q[IdxW'(bidx_q)]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      max_q   <= '0;
      tot_q   <= '0;
      for (int k = 0; k < NUM_BUCKETS; k++) cnt_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
      if (state_q == ST_DONE) ov_q <= 1'b1;
      if (state_q == ST_ADD_UPD) begin
        if (cnt_q[i_q] != CntMax) cnt_q[i_q] <= cnt_q[i_q] + 1'b1;
        if (tot_q != CntMax) tot_q <= tot_q + 1'b1;
        if (smp_q > max_q) max_q <= smp_q;
      end
      if (state_q == ST_CLEAR) begin
        cnt_q[i_q] <= '0;
        max_q      <= '0;
        tot_q      <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      smp_q  <= s_axis_tdata[63:0];
      bval_q <= s_axis_tdata[127:64];
      bidx_q <= s_axis_tdata[131:128];
      pct_q  <= s_axis_tdata[148:132];
      i_q    <= '0;
      sub_q  <= '0;
      sum_q  <= '0;
      lcum_q <= '0;
      res_q  <= '0;
    end
    unique case (state_q)
      ST_ADD_SCAN: if (!(smp_q <= bnd_q[i_q] || i_q == LastIdx)) i_q <= i_q + 1'b1;
      ST_CLEAR:    if (i_q != LastIdx) i_q <= i_q + 1'b1;
      ST_READ: begin
        if (op_q == OP_WRB && 32'(bidx_q) < NUM_BUCKETS) bnd_q[IdxW'(bidx_q)] <= bval_q;
      end
      ST_PCT_STOP: begin
        if (max_q <= bnd_q[i_q] || i_q == LastIdx - 1'b1) begin
          stop_q <= (max_q <= bnd_q[i_q]) ? i_q : LastIdx;
          i_q    <= '0;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      ST_PCT_SUM: begin
        if (i_q == stop_q) begin
          nev_q <= sat_sum;
          sum_q <= '0;
          i_q   <= '0;
        end else begin
          sum_q <= sat_sum;
          i_q   <= i_q + 1'b1;
        end
        res_q <= max_q;
      end
      ST_PCT_TGT: if (mctl.done) tgt_q <= pout;
      ST_PCT_WALK: begin
        if (sub_q == 2'd0) begin
          sub_q <= 2'd1;
        end else if (mctl.done) begin
          sub_q <= 2'd0;
          if (pout >= tgt_q) begin
            lcum_q <= sum_q;
            sum_q  <= sat_sum;
            res_q  <= (lp > max_q) ? max_q : lp;
          end else begin
            lcum_q <= sat_sum;
            sum_q  <= sat_sum;
            i_q    <= i_q + 1'b1;
          end
        end
      end
      ST_PCT_NUM: begin
        if (sub_q == 2'd0) sub_q <= 2'd1;
        else if (mctl.done) begin
          sub_q <= sub_q + 2'd1;
          if (sub_q == 2'd2) tgt_q <= pout;
        end
        // recompute after latching walk values
        lcum_q <= lcum_q;
      end
      ST_PCT_DIV: if (ddone) res_q <= (r_sum > max_q) ? max_q : r_sum;
      default: ;
    endcase
    if (state_q == ST_DONE) out_q <= out_d;
  end

endmodule
`default_nettype wire

@@ rtl/bhp_mul.sv @@
// ----------------------------------------------------------------------------
// bhp_mul: iterative wide multiplier
// Radix-16 shift-add multiply of a 192-bit operand by a 64-bit operand,
// product truncated to 192 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module bhp_mul
  import bhp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WideW-1:0] a_i,
  input  wire logic [ValW-1:0]  b_i,
  output      mul_ctl_t         ctl_o,
  output      logic [WideW-1:0] p_o
);

  logic [WideW-1:0] acc_q, acc_d, a_q, a_d;
  logic [ValW-1:0]  b_q, b_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [WideW+3:0] part;

  always_comb begin
    part   = {4'd0, a_q} * {{(WideW){1'b0}}, b_q[3:0]};
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + part[WideW-1:0];
      a_d   = a_q << 4;
      b_d   = b_q >> 4;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};
  assign p_o   = acc_q;

endmodule
`default_nettype wire

@@ rtl/bhp_div.sv @@
// ----------------------------------------------------------------------------
// bhp_div: restoring divider
// One quotient bit per cycle of a 192-bit dividend by a 192-bit divisor;
// returns the low 64 bits of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module bhp_div
  import bhp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WideW-1:0] num_i,
  input  wire logic [WideW-1:0] den_i,
  output      logic             done_o,
  output      logic [ValW-1:0]  quo_o
);

  logic [WideW-1:0] rem_q, num_q, den_q, quo_q;
  logic [WideW:0]   trial;
  logic [7:0]       cnt_q;
  logic             busy_q, done_q;

  assign trial = {rem_q, num_q[WideW-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 8'(WideW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 8'd1;
        if (cnt_q == 8'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      if (!trial[WideW]) begin
        rem_q <= trial[WideW-1:0];
        quo_q <= {quo_q[WideW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[WideW-2:0], num_q[WideW-1]};
        quo_q <= {quo_q[WideW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q[ValW-1:0];

endmodule
`default_nettype wire

@@ rtl/bhp_checker.sv @@
// ----------------------------------------------------------------------------
// bhp_checker: port-level checks of the histogram
// Results hold while stalled, no item while busy or while a result is pending.
// ----------------------------------------------------------------------------
`default_nettype none
module bhp_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [199:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while busy");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("item taken while result pending");

endmodule

bind bucket_histogram_percentile bhp_checker u_bhp_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: bucket histogram with interpolated percentile
// Drives add, percentile, clear, write-bound, read and unused-opcode items
// over the input stream, predicts every result with a behavioral histogram
// and compares each output item field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import bhp_pkg::*;

  localparam int unsigned NB = 16;
  localparam longint unsigned CYCLE_LIMIT = 64'd6000000;

  typedef struct packed {
    logic [63:0] maxv;
    logic [31:0] total;
    logic [3:0]  hit;
    logic [31:0] cnt;
    logic [63:0] pct;
  } hist_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;

  bucket_histogram_percentile u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predicted histogram state
  logic [63:0] bounds [NB];
  logic [31:0] counts [NB];
  logic [63:0] largest;
  logic [31:0] total;

  hist_res_t   pending_results [$];
  int          mismatches = 0;
  longint unsigned cycles = 0;
  logic        rx_enable = 1'b0;
  bit          stall_free = 1'b0;
  int          rx_wait = 0;

  function automatic hist_res_t predict_item(logic [2:0] op, logic [63:0] sv,
                                             logic [63:0] bv, logic [3:0] idx,
                                             logic [16:0] pm);
    hist_res_t r;
    int h;
    int stop;
    logic [63:0] nev;
    logic [64:0] s65;
    logic [191:0] tgt, cum, num, den;
    logic [63:0] lc, sum, lp, rp, span, diff, q, res;
    bit found;
    r = '0;
    case (op)
      OP_ADD: begin
        h = NB - 1;
        for (int i = NB - 1; i >= 0; i--) if (sv <= bounds[i]) h = i;
        if (counts[h] != 32'hFFFF_FFFF) counts[h]++;
        if (total != 32'hFFFF_FFFF) total++;
        if (sv > largest) largest = sv;
        r.hit = h[3:0];
      end
      OP_PCT: begin
        stop = NB - 1;
        for (int i = NB - 2; i >= 0; i--) if (largest <= bounds[i]) stop = i;
        nev = '0;
        for (int i = 0; i <= stop; i++) nev = nev + 64'(counts[i]);
        tgt = 192'(nev) * 192'(pm);
        lc = '0;
        found = 1'b0;
        res = largest;
        for (int i = 0; i < stop && !found; i++) begin
          s65 = 65'(lc) + 65'(counts[i]);
          sum = s65[64] ? '1 : s65[63:0];
          cum = 192'(sum) * 192'(PctScale);
          if (cum >= tgt) begin
            found = 1'b1;
            lp = bounds[(i == 0) ? 0 : i - 1];
            rp = bounds[i];
            span = (rp > lp) ? rp - lp : '0;
            diff = sum - lc;
            q = '0;
            if (diff != 0 && span != 0) begin
              num = (tgt - 192'(lc) * 192'(PctScale)) * 192'(span);
              den = 192'(diff) * 192'(PctScale);
              q = 64'(num / den);
            end
            res = lp + q;
            if (res > largest) res = largest;
          end
          lc = sum;
        end
        r.pct = res;
      end
      OP_CLEAR: begin
        for (int i = 0; i < NB; i++) counts[i] = '0;
        largest = '0;
        total = '0;
      end
      OP_WRB: bounds[idx] = bv;
      OP_READ: r.cnt = counts[idx];
      default: ;
    endcase
    r.total = total;
    r.maxv = largest;
    return r;
  endfunction

  task automatic send_item(logic [2:0] op, logic [63:0] sv = '0, logic [63:0] bv = '0,
                           logic [3:0] idx = '0, logic [16:0] pm = '0);
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b0, pm, idx, bv, sv};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_item(op, sv, bv, idx, pm));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // receiver: random stalls, check each accepted result against the oldest
  always @(posedge clk_i) begin
    hist_res_t got, exp_r;
    cycles <= cycles + 1;
    if (rx_enable) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[195:0];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", got);
        end else begin
          exp_r = pending_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: pct %h/%h cnt %h/%h hit %h/%h total %h/%h max %h/%h",
                       exp_r.pct, got.pct, exp_r.cnt, got.cnt, exp_r.hit, got.hit,
                       exp_r.total, got.total, exp_r.maxv, got.maxv);
          end
        end
        rx_wait = stall_free ? 0 : $urandom_range(0, 9);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // random sample biased toward the current bounds
  function automatic logic [63:0] pick_sample();
    logic [63:0] b;
    b = bounds[$urandom_range(0, NB - 1)];
    case ($urandom_range(0, 5))
      0: return rnd64();
      1: return b;
      2: return b + 1;
      3: return b - 1;
      4: return '1;
      default: return b - $urandom_range(0, 1000);
    endcase
  endfunction

  function automatic logic [16:0] pick_pct();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd100000;
      2: return 17'($urandom_range(100001, 131071));
      3: return 17'd99999;
      default: return 17'($urandom_range(0, 100000));
    endcase
  endfunction

  task automatic load_ascending_bounds(logic [63:0] base, logic [63:0] step);
    for (int i = 0; i < NB; i++) send_item(OP_WRB, '0, base + step * i, 4'(i));
  endtask

  task automatic test_directed();
    load_ascending_bounds(64'd10, 64'd10);
    send_item(OP_ADD, 64'd0);
    send_item(OP_ADD, 64'd10);
    send_item(OP_ADD, 64'd11);
    send_item(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_PCT, '0, '0, '0, 17'd0);
    send_item(OP_PCT, '0, '0, '0, 17'd50000);
    send_item(OP_PCT, '0, '0, '0, 17'd100000);
    send_item(OP_PCT, '0, '0, '0, 17'h1FFFF);
    send_item(OP_READ, '0, '0, 4'd15);
    send_item(OP_READ, '0, '0, 4'd0);
    send_item(3'd5, rnd64(), rnd64(), 4'hF, 17'h1FFFF);
    send_item(3'd7);
    send_item(OP_CLEAR);
    send_item(OP_PCT, '0, '0, '0, 17'd50000);
    // descending bound, empty bucket reached
    send_item(OP_WRB, '0, 64'd5, 4'd3);
    send_item(OP_ADD, 64'd35);
    send_item(OP_ADD, 64'd25);
    send_item(OP_PCT, '0, '0, '0, 17'd99999);
    wait_drained();
  endtask

  task automatic test_random_sequences(int n_items);
    int k;
    k = 0;
    while (k < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) begin
          load_ascending_bounds(rnd64() >> $urandom_range(1, 63),
                                rnd64() >> $urandom_range(4, 63));
          k += NB;
        end else begin
          for (int i = 0; i < 4; i++) send_item(OP_WRB, '0, rnd64(), 4'($urandom()));
          k += 4;
        end
      end
      case ($urandom_range(0, 19))
        0: send_item(OP_CLEAR);
        1, 2, 3: send_item(OP_PCT, rnd64(), rnd64(), 4'($urandom()), pick_pct());
        4, 5: send_item(OP_READ, rnd64(), rnd64(), 4'($urandom()), 17'($urandom()));
        6: send_item(3'($urandom_range(5, 7)), rnd64(), rnd64(), 4'($urandom()));
        default: send_item(OP_ADD, pick_sample(), rnd64(), 4'($urandom()),
                           17'($urandom()));
      endcase
      k++;
      if (k % 200 == 0) stall_free = ~stall_free;
    end
    stall_free = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    rx_enable <= 1'b1;
    for (int i = 0; i < NB; i++) begin
      bounds[i] = '0;
      counts[i] = '0;
    end
    largest = '0;
    total = '0;
    @(posedge clk_i);
    test_directed();
    test_random_sequences(1830);
    if (mismatches == 0 && pending_results.size() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

endmodule
`default_nettype wire
